// ===== rtl/bca_pkg.sv =====
// Package for the breath cycle analyser: widths, register codes, reset values
// and the divider status type. No dependencies; used by the top level and the divider.
`default_nettype none

package bca_pkg;

  // Interval ring geometry.
  localparam int RING_DEPTH = 8;
  localparam int POS_W      = $clog2(RING_DEPTH);
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);
  localparam int IVL_W      = 16;
  localparam int SUM_W      = IVL_W + $clog2(RING_DEPTH);

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_MIN_PERIOD = 3'd1,
    REG_MAX_PERIOD = 3'd2,
    REG_APNEA_TIMEOUT = 3'd3,
    REG_AVG_DEPTH = 3'd4
  } cfg_reg_t;

  localparam logic [14:0] THRESHOLD_RST = 15'd60;
  localparam logic [15:0] MIN_PERIOD_RST = 16'd1500;
  localparam logic [15:0] MAX_PERIOD_RST = 16'd12000;
  localparam logic [19:0] APNEA_TIMEOUT_RST = 20'd10000;
  localparam logic [3:0]  AVG_DEPTH_RST = 4'd5;

  // Stream payload widths, padded to whole bytes.
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 120;

  // Shared divider: 16 quotient bits, dividend shifted in from the top.
  localparam int DIV_DVD_W = 48;
  localparam int DIV_DSR_W = 32;
  localparam int DIV_Q_W   = 16;
  localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

  // 60000 ms per minute in UQ8.8; a mean at or below the limit saturates.
  localparam logic [DIV_DVD_W-1:0] RATE_NUMER = DIV_DVD_W'(60000 * 256);
  localparam logic [IVL_W-1:0] RATE_SAT_MEAN = IVL_W'((60000 * 256) >> DIV_Q_W);
  localparam logic [DIV_Q_W-1:0] Q_SAT = '1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/breath_cycle_analyzer_top.sv =====
// Breath cycle analyser top level: crossing detection, interval ring in RAM,
// rate and inhale/exhale ratio through a shared divider, output register.
// Depends on bca_pkg, bca_ram and bca_div.
//
//  Channel  Direction  Signals                       Payload
//  s_       in         s_tvalid s_tready s_tdata     one pressure sample
//  m_       out        m_tvalid m_tready m_tdata     one result per sample
//  cfg_     in         cfg_valid cfg_ready           register index and data
//
// A sample that adds no interval to the ring goes from the transfer to the
// emit step, which loads the output register. A sample that adds an interval also
// sums the newest entries through the single RAM read port and runs up to
// three 16-step divisions before the output register is loaded.
// Reset is synchronous and clears all held state; the ring needs no clearing.
// A stalled output holds one result while the next sample is processed.
`default_nettype none

module breath_cycle_analyzer_top
  import bca_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output      logic                  s_tready,
  // s_tdata: sample_pressure[15:0], timestamp_ms[47:16]
  input  wire logic [S_TDATA_W-1:0]  s_tdata,
  output      logic                  m_tvalid,
  input  wire logic                  m_tready,
  // m_tdata: breath_rate[15:0], in_ex_ratio[31:16], amplitude[46:32],
  // inhale_duration[78:47], exhale_duration[110:79], apnea[111],
  // inhale_onset[112], exhale_onset[113], zero padding[119:114]
  output      logic [M_TDATA_W-1:0]  m_tdata,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_SUM       = 7'b0000010,
    ST_DIV_MEAN  = 7'b0000100,
    ST_DIV_RATE  = 7'b0001000,
    ST_RATIO     = 7'b0010000,
    ST_DIV_RATIO = 7'b0100000,
    ST_EMIT      = 7'b1000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [14:0] threshold;
  logic [15:0] min_period;
  logic [15:0] max_period;
  logic [19:0] apnea_timeout;
  logic [3:0]  avg_depth;

  // Held breath state.
  logic              was_positive;
  logic [31:0]       last_inhale_time;
  logic [31:0]       last_exhale_time;
  logic [31:0]       inhale_held;
  logic [31:0]       exhale_held;
  logic [POS_W-1:0]  ring_position;
  logic [FILL_W-1:0] ring_fill;
  logic [14:0]       running_peak;
  logic [14:0]       amplitude_held;
  logic [15:0]       rate_held;
  logic [15:0]       ratio_held;

  // Per-item flags waiting for the output register.
  logic apnea_q;
  logic rise_q;
  logic fall_q;

  // Ring summation.
  logic [FILL_W-1:0] avg_cnt;
  logic [FILL_W-1:0] issue_idx;
  logic              rd_pending;
  logic [POS_W-1:0]  rd_addr;
  logic [SUM_W-1:0]  sum;
  logic [IVL_W-1:0]  ring_rdata;
  logic              rd_en;

  // Divider interface.
  logic                 div_start;
  logic [DIV_DVD_W-1:0] div_dividend;
  logic [DIV_DSR_W-1:0] div_divisor;
  logic [DIV_Q_W-1:0]   div_q;
  div_stat_t            div_stat;

  // Sample decode.
  logic               accept;
  logic signed [15:0] pressure;
  logic [31:0]        ts;
  logic               positive;
  logic               rise;
  logic               fall;
  logic [31:0]        since_inhale;
  logic [31:0]        since_exhale;
  logic               push;
  logic               apnea_now;
  logic [14:0]        peak_base;
  logic [14:0]        peak_new;
  logic [FILL_W-1:0]  fill_new;
  logic [3:0]         avg_eff;
  logic [FILL_W-1:0]  cnt_new;
  logic [IVL_W-1:0]   mean_v;
  logic               ratio_sat;
  logic               ratio_ok;
  logic               out_free;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign pressure = $signed(s_tdata[15:0]);
  assign ts       = s_tdata[47:16];

  // Crossing detection against the threshold, compared as signed values.
  assign positive     = $signed({pressure[15], pressure}) > $signed({2'b00, threshold});
  assign rise         = positive && !was_positive;
  assign fall         = !positive && was_positive;
  assign since_inhale = ts - last_inhale_time;
  assign since_exhale = ts - last_exhale_time;
  assign push         = rise && (last_inhale_time != 32'd0)
                        && (since_inhale > {16'd0, min_period})
                        && (since_inhale < {16'd0, max_period});
  assign apnea_now    = !rise && (last_inhale_time != 32'd0)
                        && (since_inhale > {12'd0, apnea_timeout});

  // Peak tracking; the peak restarts at each inhale onset.
  assign peak_base = rise ? 15'd0 : running_peak;
  assign peak_new  = (positive && (pressure[14:0] > peak_base)) ? pressure[14:0] : peak_base;

  // Ring occupancy and the number of newest entries to average.
  assign fill_new = (ring_fill < FILL_W'(RING_DEPTH)) ? ring_fill + 1'b1 : ring_fill;
  assign avg_eff  = (avg_depth == 4'd0) ? 4'd1 : avg_depth;
  assign cnt_new  = ({4'd0, avg_eff} > 8'(fill_new)) ? fill_new : FILL_W'(avg_eff);

  // Ratio decision: saturate when inhale >= 16 * exhale.
  assign ratio_ok  = (inhale_held != 32'd0) && (exhale_held != 32'd0);
  assign ratio_sat = {4'd0, inhale_held} >= {exhale_held, 4'd0};

  assign mean_v = (div_q == '0) ? IVL_W'(1) : div_q;
  assign rd_en  = (state == ST_SUM) && (issue_idx < avg_cnt);

  // Divider start and operand selection.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIV_DVD_W'(sum);
    div_divisor  = DIV_DSR_W'(avg_cnt);
    case (state)
      ST_SUM: begin
        div_start = !rd_en && !rd_pending;
      end
      ST_DIV_MEAN: begin
        div_dividend = RATE_NUMER;
        div_divisor  = DIV_DSR_W'(mean_v);
        div_start    = div_stat.done && (mean_v > RATE_SAT_MEAN);
      end
      ST_RATIO: begin
        div_dividend = {4'd0, inhale_held, 12'd0};
        div_divisor  = exhale_held;
        div_start    = ratio_ok && !ratio_sat;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= THRESHOLD_RST;
      min_period    <= MIN_PERIOD_RST;
      max_period    <= MAX_PERIOD_RST;
      apnea_timeout <= APNEA_TIMEOUT_RST;
      avg_depth     <= AVG_DEPTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD:     threshold     <= cfg_data[14:0];
        REG_MIN_PERIOD:    min_period    <= cfg_data[15:0];
        REG_MAX_PERIOD:    max_period    <= cfg_data[15:0];
        REG_APNEA_TIMEOUT: apnea_timeout <= cfg_data;
        REG_AVG_DEPTH:     avg_depth     <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer and held state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      was_positive     <= 1'b0;
      last_inhale_time <= '0;
      last_exhale_time <= '0;
      inhale_held      <= '0;
      exhale_held      <= '0;
      ring_position    <= '0;
      ring_fill        <= '0;
      running_peak     <= '0;
      amplitude_held   <= '0;
      rate_held        <= '0;
      ratio_held       <= '0;
      issue_idx        <= '0;
      rd_pending       <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      // Output valid: set when a result is loaded, cleared once it is taken.
      if ((state == ST_EMIT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      rd_pending <= rd_en;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            was_positive <= positive;
            running_peak <= peak_new;
            if (rise) begin
              last_inhale_time <= ts;
              if (last_exhale_time != 32'd0) begin
                exhale_held <= since_exhale;
              end
            end else if (fall) begin
              last_exhale_time <= ts;
              amplitude_held   <= running_peak;
              if (last_inhale_time != 32'd0) begin
                inhale_held <= since_inhale;
              end
            end
            issue_idx <= '0;
            if (push) begin
              ring_position <= (ring_position == POS_W'(RING_DEPTH - 1)) ?
                               '0 : ring_position + 1'b1;
              ring_fill     <= fill_new;
              state         <= ST_SUM;
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_SUM: begin
          if (rd_en) begin
            issue_idx <= issue_idx + 1'b1;
          end
          if (div_start) begin
            state <= ST_DIV_MEAN;
          end
        end
        ST_DIV_MEAN: begin
          if (div_stat.done) begin
            if (mean_v > RATE_SAT_MEAN) begin
              state <= ST_DIV_RATE;
            end else begin
              rate_held <= Q_SAT;
              state     <= ST_RATIO;
            end
          end
        end
        ST_DIV_RATE: begin
          if (div_stat.done) begin
            rate_held <= div_q;
            state     <= ST_RATIO;
          end
        end
        ST_RATIO: begin
          if (!ratio_ok) begin
            state <= ST_EMIT;
          end else if (ratio_sat) begin
            ratio_held <= Q_SAT;
            state      <= ST_EMIT;
          end else begin
            state <= ST_DIV_RATIO;
          end
        end
        ST_DIV_RATIO: begin
          if (div_stat.done) begin
            ratio_held <= div_q;
            state      <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Per-item payload registers: flags, read walk, running sum, output data.
  always_ff @(posedge clk) begin
    if (accept) begin
      apnea_q <= apnea_now;
      rise_q  <= rise;
      fall_q  <= fall;
      avg_cnt <= cnt_new;
      rd_addr <= ring_position;
      sum     <= '0;
    end else begin
      if (rd_en) begin
        rd_addr <= (rd_addr == '0) ? POS_W'(RING_DEPTH - 1) : rd_addr - 1'b1;
      end
      if (rd_pending) begin
        sum <= sum + SUM_W'(ring_rdata);
      end
    end
    if ((state == ST_EMIT) && out_free) begin
      m_tdata <= {6'd0, fall_q, rise_q, apnea_q, exhale_held, inhale_held,
                  amplitude_held, ratio_held, rate_held};
    end
  end

  // Interval ring.
  bca_ram #(
    .WIDTH(IVL_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (accept && push),
    .waddr(ring_position),
    .wdata(since_inhale[IVL_W-1:0]),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(ring_rdata)
  );

  // Shared divider for mean, rate and ratio.
  bca_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .quotient(div_q),
    .stat    (div_stat)
  );

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    ring_fill <= FILL_W'(RING_DEPTH)) else $error("ring fill beyond ring depth");

  a_issue_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM) |-> (issue_idx <= avg_cnt))
    else $error("ring read walk overran its count");

  a_done_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIV_MEAN || state == ST_DIV_RATE ||
                       state == ST_DIV_RATIO))
    else $error("division finished outside a waiting state");

  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_EMIT))
    else $error("result presented without passing the emit step");

  a_idle_when_div_busy: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> !s_tready) else $error("sample taken while a division runs");

endmodule

`default_nettype wire

// ===== rtl/bca_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module bca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bca_div.sv =====
// Restoring divider producing one quotient bit per cycle, 16 bits in all.
// The caller guarantees the quotient fits, i.e. dividend >> 16 < divisor.
// Depends on bca_pkg.
`default_nettype none

module bca_div
  import bca_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [DIV_DVD_W-1:0] dividend,
  input  wire logic [DIV_DSR_W-1:0] divisor,
  output      logic [DIV_Q_W-1:0]   quotient,
  output      div_stat_t            stat
);

  logic [DIV_DSR_W-1:0] rem;
  logic [DIV_Q_W-1:0]   low_bits;
  logic [DIV_DSR_W-1:0] dsr;
  logic [DIV_CNT_W-1:0] steps;
  logic                 busy;
  logic                 done;
  logic [DIV_DSR_W:0]   trial;
  logic                 ge;

  // One trial subtraction per cycle.
  assign trial = {rem, low_bits[DIV_Q_W-1]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= DIV_CNT_W'(DIV_Q_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder, remaining dividend bits and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend[DIV_DVD_W-1:DIV_Q_W];
      low_bits <= dividend[DIV_Q_W-1:0];
      dsr      <= divisor;
    end else if (busy) begin
      rem      <= ge ? DIV_DSR_W'(trial - {1'b0, dsr}) : trial[DIV_DSR_W-1:0];
      low_bits <= {low_bits[DIV_Q_W-2:0], 1'b0};
      quotient <= {quotient[DIV_Q_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without a running division");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy) else $error("divider started while busy");

endmodule

`default_nettype wire
